FILE: rtl/core/tsc_pkg.sv
// Shared types, constants and the CRC-8 step function for the scratchpad checker.
package tsc_pkg;

    localparam logic [7:0]  CRC_POLY     = 8'h8C;
    localparam logic [15:0] POWER_ON_RAW = 16'h0550;
    localparam logic [3:0]  CRC_BYTES    = 4'd8;
    localparam logic [3:0]  FRAME_DONE   = 4'd9;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_CRC_ERR  = 2'd1;
    localparam logic [1:0] STAT_POWER_ON = 2'd2;

    typedef struct packed {
        logic [7:0] scratch_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic [1:0]         read_status;
    } t_out;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = data;
        for (int k = 0; k < 8; k++) begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

FILE: rtl/core/thermometer_scratchpad_checker.sv
// Top level of the thermometer scratchpad checker: input register, frame logic, result register.
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_ready  | i_in  (t_in: scratch_byte, frame_start)
//  out     | output    | o_out_valid / i_out_ready| o_out (t_out: temp_centi, read_status)
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (reject_power_on_value)
//
// One beat per cycle sustained unless a ninth byte meets a full output; a ninth byte's result
// passes from the input register through CRC/decode and conversion into the result register.
// Reset clears position, CRC, stored bytes and valids; the power-on check resets enabled.
// A stalled result holds the result register; the input register still drains bytes
// that give no result, and back-pressures only when a ninth byte meets a full output.
module thermometer_scratchpad_checker
    import tsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    logic r_reject;
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;
    logic out_free;
    logic drain;
    logic has_result;
    t_out result;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign drain       = r_in_valid && (!has_result || out_free);
    assign o_in_ready  = !r_in_valid || drain;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    tsc_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (drain),
        .i_beat       (r_in),
        .i_reject     (r_reject),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reject <= 1'b1;
        end else if (i_cfg_valid) begin
            r_reject <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= drain && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain && has_result) begin
            r_out <= result;
        end
    end

endmodule

FILE: rtl/core/tsc_centi.sv
// Raw 1/16 degree reading to saturated hundredths of a degree.
module tsc_centi
    import tsc_pkg::*;
(
    input  logic [15:0]        i_raw,
    output logic signed [15:0] o_centi
);

    logic signed [22:0] prod;
    logic signed [22:0] biased;
    logic signed [18:0] quot;

    always_comb begin
        prod   = $signed({{7{i_raw[15]}}, i_raw}) * 23'sd100;
        biased = prod + (prod[22] ? 23'sd15 : 23'sd0);
        quot   = 19'(biased >>> 4);
        if (quot > 19'sd32767) begin
            o_centi = 16'sh7FFF;
        end else if (quot < -19'sd32768) begin
            o_centi = 16'sh8000;
        end else begin
            o_centi = quot[15:0];
        end
    end

endmodule

FILE: rtl/core/tsc_frame.sv
// Frame tracking: byte position, running CRC, raw temperature bytes and result decode.
module tsc_frame
    import tsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_in  i_beat,
    input  logic i_reject,
    output logic o_has_result,
    output t_out o_result
);

    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_low, n_low;
    logic [7:0]  r_high, n_high;
    logic [3:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic [15:0] raw;
    logic signed [15:0] centi;

    assign pos_eff = i_beat.frame_start ? 4'd0 : r_pos;
    assign crc_eff = i_beat.frame_start ? 8'd0 : r_crc;
    assign raw     = {r_high, r_low};

    tsc_centi u_centi (
        .i_raw   (raw),
        .o_centi (centi)
    );

    always_comb begin
        n_pos        = r_pos;
        n_crc        = r_crc;
        n_low        = r_low;
        n_high       = r_high;
        o_has_result = 1'b0;
        o_result     = '0;
        if (pos_eff < CRC_BYTES) begin
            n_crc = crc8_update(crc_eff, i_beat.scratch_byte);
            n_pos = pos_eff + 4'd1;
            if (pos_eff == 4'd0) begin
                n_low = i_beat.scratch_byte;
            end
            if (pos_eff == 4'd1) begin
                n_high = i_beat.scratch_byte;
            end
        end else begin
            n_pos = FRAME_DONE;
            n_crc = crc_eff;
            if (pos_eff == CRC_BYTES) begin
                o_has_result = 1'b1;
                if (crc_eff != i_beat.scratch_byte) begin
                    o_result.read_status = STAT_CRC_ERR;
                end else if (i_reject && raw == POWER_ON_RAW) begin
                    o_result.read_status = STAT_POWER_ON;
                end else begin
                    o_result.read_status = STAT_OK;
                    o_result.temp_centi  = centi;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= '0;
            r_low  <= '0;
            r_high <= '0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= FRAME_DONE)
        else $error("byte position out of range");

    a_start_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_beat.frame_start |=> r_pos == 4'd1)
        else $error("frame start did not restart position");

    a_done_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_has_result |=> r_pos == FRAME_DONE)
        else $error("frame not closed after result");

    a_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has_result && o_result.read_status != STAT_OK |-> o_result.temp_centi == 16'sd0)
        else $error("temperature not zero on error status");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for thermometer_scratchpad_checker with a frame-level scoreboard.
`timescale 1ns / 100ps

module testbench;
    import tsc_pkg::*;

    localparam int unsigned PHASE_ITEMS = 260;
    localparam int unsigned LONG_HOLD   = 400;

    class scratchpad_scoreboard;
        bit          reject_por = 1'b1;
        logic [7:0]  crc_acc    = '0;
        logic [3:0]  pos        = '0;
        logic [7:0]  temp_lo    = '0;
        logic [7:0]  temp_hi    = '0;
        t_out        readings_due[$];
        int unsigned errors     = 0;

        static function logic [7:0] crc_fold(logic [7:0] acc, logic [7:0] data);
            logic [7:0] c;
            c = acc;
            for (int k = 0; k < 8; k++) begin
                c = (c >> 1) ^ ((c[0] ^ data[k]) ? CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        function void set_reject(logic value);
            reject_por = value;
        endfunction

        // Returns 1 when the byte is taken, 0 when the block ignores it.
        function bit note_byte(t_in beat);
            t_out want;
            int   raw;
            int   centi;
            if (beat.frame_start) begin
                pos     = '0;
                crc_acc = '0;
            end
            if (pos < CRC_BYTES) begin
                if (pos == 4'd0) temp_lo = beat.scratch_byte;
                if (pos == 4'd1) temp_hi = beat.scratch_byte;
                crc_acc = crc_fold(crc_acc, beat.scratch_byte);
                pos     = pos + 4'd1;
                return 1'b1;
            end
            if (pos == CRC_BYTES) begin
                pos   = FRAME_DONE;
                raw   = $signed({temp_hi, temp_lo});
                centi = 0;
                if (crc_acc != beat.scratch_byte) begin
                    want.read_status = STAT_CRC_ERR;
                end else if (reject_por && {temp_hi, temp_lo} == POWER_ON_RAW) begin
                    want.read_status = STAT_POWER_ON;
                end else begin
                    want.read_status = STAT_OK;
                    centi = (raw * 100) / 16;
                    if (centi > 32767) centi = 32767;
                    if (centi < -32768) centi = -32768;
                end
                want.temp_centi = centi[15:0];
                readings_due.push_back(want);
                return 1'b1;
            end
            pos = FRAME_DONE;
            return 1'b0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_reading(t_out got);
            t_out want;
            if (readings_due.size() == 0) begin
                report($sformatf("unexpected result status %0d temp %0d",
                                 got.read_status, got.temp_centi));
                return;
            end
            want = readings_due.pop_front();
            if (got.read_status !== want.read_status)
                report($sformatf("read_status got %0d want %0d",
                                 got.read_status, want.read_status));
            if (got.temp_centi !== want.temp_centi)
                report($sformatf("temp_centi got %0d want %0d",
                                 got.temp_centi, want.temp_centi));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;

    scratchpad_scoreboard sb = new();
    int unsigned taken_count  = 0;
    int unsigned results_seen = 0;
    int unsigned long_holds   = 0;
    bit          calm         = 1'b0;

    thermometer_scratchpad_checker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_raw();
        int corner_raw [15] = '{0, 1, -1, 32767, -32768, 'h0550, 'h0551, 'h054F,
                                5242, 5243, -5243, -5244, -8, -15, 'h00FF};
        if ($urandom_range(0, 2) == 0) return 16'(corner_raw[$urandom_range(0, 14)]);
        if ($urandom_range(0, 1) == 0) return 16'(int'($urandom_range(0, 2880)) - 880);
        return 16'($urandom);
    endfunction

    task automatic put_byte(input logic [7:0] data, input logic start);
        t_in         beat;
        int unsigned gap;
        beat.scratch_byte = data;
        beat.frame_start  = start;
        i_in_valid <= 1'b1;
        i_in       <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (sb.note_byte(beat)) taken_count++;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [15:0] raw, input logic start,
                              input bit corrupt, input int unsigned len);
        logic [7:0] pad [9];
        logic [7:0] crc;
        crc    = '0;
        pad[0] = raw[7:0];
        pad[1] = raw[15:8];
        for (int i = 2; i < 8; i++) pad[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 8; i++) crc = scratchpad_scoreboard::crc_fold(crc, pad[i]);
        pad[8] = corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc;
        for (int i = 0; i < len; i++) put_byte(pad[i], start && i == 0);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.readings_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reject(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_reject(value);
    endtask

    task automatic run_phase(input int unsigned target);
        int unsigned goal;
        int unsigned r;
        int unsigned frames;
        goal   = taken_count + target;
        frames = 0;
        while (taken_count < goal) begin
            if (frames % 8 == 0) calm = ($urandom_range(0, 3) == 0);
            frames++;
            r = $urandom_range(0, 99);
            if (r < 72) begin
                send_frame(pick_raw(), 1'b1, $urandom_range(0, 9) == 0, 9);
            end else if (r < 80) begin
                send_frame(pick_raw(), 1'b1, 1'b0, $urandom_range(1, 8));
            end else if (r < 84) begin
                send_frame(pick_raw(), 1'b0, 1'b0, 9);
            end else if (r < 92) begin
                repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) put_byte(8'($urandom), 1'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_reading(o_out);
            results_seen++;
        end
    end

    initial begin
        int unsigned n;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ((long_holds == 0 && results_seen >= 10) ||
                (long_holds == 1 && results_seen >= 50)) begin
                long_holds++;
                n = LONG_HOLD;
            end else begin
                n = pick_gap();
            end
            if (n != 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first frame without frame_start, power-on value rejected
        send_frame(POWER_ON_RAW, 1'b0, 1'b0, 9);
        // stray beats after a finished frame
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        // drop a partial frame, then a bad CRC over the power-on value
        send_frame(16'h8000, 1'b1, 1'b0, 3);
        send_frame(POWER_ON_RAW, 1'b1, 1'b1, 9);

        for (int p = 0; p < 4; p++) begin
            settle();
            write_reject(p[0]);
            run_phase(PHASE_ITEMS);
        end
        settle();

        if (sb.errors == 0 && sb.readings_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
